>>> rtl/sset_pkg.sv
// ---------------------------------------------------------------------------
// sset_pkg
// Shared types and constants for the sorted set block.
// ---------------------------------------------------------------------------
`default_nettype none

package sset_pkg;

  localparam int CAPACITY_DEF = 32;
  localparam int VAL_W        = 32;
  localparam int SIZE_W       = 6;
  localparam int ACT_W        = 2;
  localparam int STAT_W       = 3;

  typedef enum logic [ACT_W-1:0] {
    ACT_INSERT = 2'd0,
    ACT_DELETE = 2'd1,
    ACT_DUMP   = 2'd2,
    ACT_NOP    = 2'd3
  } action_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK       = 3'd0,
    ST_DUP      = 3'd1,
    ST_NOTFOUND = 3'd2,
    ST_FULL     = 3'd3,
    ST_EMPTY    = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS,
    S_DEL,
    S_DUMP,
    S_RESP
  } state_t;

endpackage

`default_nettype wire

>>> rtl/sset_ram.sv
// ---------------------------------------------------------------------------
// sset_ram
// Simple dual-port store, one write and one registered read per cycle.
// ---------------------------------------------------------------------------
`default_nettype none

module sset_ram #(
  parameter int DEPTH = sset_pkg::CAPACITY_DEF,
  parameter int AW    = 5
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [AW-1:0]            waddr,
  input  wire logic [sset_pkg::VAL_W-1:0] wdata,
  input  wire logic [AW-1:0]            raddr,
  output logic      [sset_pkg::VAL_W-1:0] rdata
);
  import sset_pkg::*;

  logic [VAL_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> rtl/sorted_set_insert_delete.sv
// ---------------------------------------------------------------------------
// sorted_set_insert_delete
// Ascending set of distinct signed values kept in one RAM, with insert,
// delete and ascending dump.
// ---------------------------------------------------------------------------
//  channel  handshake            payload
//  in       in_valid / in_stall  action, value
//  out      out_valid/ out_stall status, entry, size_now, final_res
//
//  Insert/delete: one linear pass over the RAM, reading one entry per cycle
//  and shifting on the fly.
//  Dump: one transfer per cycle while out_stall is low.
//  Reset clears the fill count; the RAM needs no clearing pass.
//  in_stall is high while an operation is in progress.
// ---------------------------------------------------------------------------
`default_nettype none

module sorted_set_insert_delete #(
  parameter int CAPACITY = sset_pkg::CAPACITY_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [sset_pkg::ACT_W-1:0]    action,
  input  wire logic signed [sset_pkg::VAL_W-1:0] value,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic      [sset_pkg::STAT_W-1:0]   status,
  output logic signed [sset_pkg::VAL_W-1:0]  entry,
  output logic      [sset_pkg::SIZE_W-1:0]   size_now,
  output logic                               final_res
);
  import sset_pkg::*;

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  state_t state, state_next;
  logic [CW-1:0] idx, idx_next;
  logic [CW-1:0] count, count_next;
  logic signed [VAL_W-1:0] val, val_next;
  logic [VAL_W-1:0] carry, carry_next;
  logic shifting, shifting_next;
  status_t res_status, res_status_next;

  logic out_valid_next;
  logic [STAT_W-1:0] status_next;
  logic signed [VAL_W-1:0] entry_next;
  logic [SIZE_W-1:0] size_now_next;
  logic final_res_next;

  logic we;
  logic [AW-1:0] waddr, raddr;
  logic [VAL_W-1:0] wdata, rdata;

  logic accept, can_load, at_end, d_lt, d_eq, full, dump_last;

  sset_ram #(
    .DEPTH(CAPACITY),
    .AW   (AW)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  assign in_stall  = (state != S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign can_load  = !out_valid || !out_stall;
  assign at_end    = (idx == count);
  assign d_lt      = $signed(rdata) < val;
  assign d_eq      = (rdata == val);
  assign full      = (count == CW'(CAPACITY));
  assign dump_last = (CW'(idx + 1'b1) == count);

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          case (action_t'(action))
            ACT_INSERT: state_next = S_INS;
            ACT_DELETE: state_next = S_DEL;
            ACT_DUMP:   state_next = (count == '0) ? S_RESP : S_DUMP;
            default:    state_next = S_RESP;
          endcase
        end
      end
      S_INS: begin
        if (at_end || (!shifting && !d_lt && (d_eq || full))) begin
          state_next = S_RESP;
        end
      end
      S_DEL: begin
        if (at_end || (!shifting && !d_lt && !d_eq)) begin
          state_next = S_RESP;
        end
      end
      S_DUMP: begin
        if (can_load && dump_last) begin
          state_next = S_IDLE;
        end
      end
      S_RESP: begin
        if (can_load) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    idx_next        = idx;
    count_next      = count;
    val_next        = val;
    carry_next      = carry;
    shifting_next   = shifting;
    res_status_next = res_status;
    raddr           = '0;
    we              = 1'b0;
    waddr           = AW'(idx);
    wdata           = carry;
    out_valid_next  = out_valid && out_stall;
    status_next     = status;
    entry_next      = entry;
    size_now_next   = size_now;
    final_res_next  = final_res;

    case (state)
      S_IDLE: begin
        if (accept) begin
          val_next        = value;
          idx_next        = '0;
          shifting_next   = 1'b0;
          res_status_next = (action_t'(action) == ACT_DUMP) ? ST_EMPTY : ST_OK;
        end
      end
      S_INS: begin
        raddr = AW'(idx + 1'b1);
        if (at_end) begin
          if (shifting) begin
            we              = 1'b1;
            count_next      = count + 1'b1;
            res_status_next = ST_OK;
          end else if (full) begin
            res_status_next = ST_FULL;
          end else begin
            we              = 1'b1;
            wdata           = val;
            count_next      = count + 1'b1;
            res_status_next = ST_OK;
          end
        end else if (!shifting) begin
          if (d_lt) begin
            idx_next = idx + 1'b1;
          end else if (d_eq) begin
            res_status_next = ST_DUP;
          end else if (full) begin
            res_status_next = ST_FULL;
          end else begin
            we            = 1'b1;
            wdata         = val;
            carry_next    = rdata;
            shifting_next = 1'b1;
            idx_next      = idx + 1'b1;
          end
        end else begin
          we         = 1'b1;
          carry_next = rdata;
          idx_next   = idx + 1'b1;
        end
      end
      S_DEL: begin
        raddr = AW'(idx + 1'b1);
        if (at_end) begin
          if (shifting) begin
            count_next      = count - 1'b1;
            res_status_next = ST_OK;
          end else begin
            res_status_next = ST_NOTFOUND;
          end
        end else if (!shifting) begin
          if (d_lt) begin
            idx_next = idx + 1'b1;
          end else if (d_eq) begin
            shifting_next = 1'b1;
            idx_next      = idx + 1'b1;
          end else begin
            res_status_next = ST_NOTFOUND;
          end
        end else begin
          we       = 1'b1;
          waddr    = AW'(idx - 1'b1);
          wdata    = rdata;
          idx_next = idx + 1'b1;
        end
      end
      S_DUMP: begin
        if (can_load) begin
          out_valid_next = 1'b1;
          status_next    = ST_OK;
          entry_next     = rdata;
          size_now_next  = SIZE_W'(count);
          final_res_next = dump_last;
          raddr          = AW'(idx + 1'b1);
          idx_next       = idx + 1'b1;
        end else begin
          raddr = AW'(idx);
        end
      end
      S_RESP: begin
        if (can_load) begin
          out_valid_next = 1'b1;
          status_next    = res_status;
          entry_next     = '0;
          size_now_next  = SIZE_W'(count);
          final_res_next = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    idx        <= idx_next;
    val        <= val_next;
    carry      <= carry_next;
    shifting   <= shifting_next;
    res_status <= res_status_next;
    status     <= status_next;
    entry      <= entry_next;
    size_now   <= size_now_next;
    final_res  <= final_res_next;
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY))
    else $error("fill count above capacity");

  a_write_busy: assert property (@(posedge clk) disable iff (rst)
    we |-> (state == S_INS || state == S_DEL))
    else $error("RAM write outside insert/delete");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && count != $past(count)) |->
      (count == CW'($past(count) + 1'b1) || count == CW'($past(count) - 1'b1)))
    else $error("fill count moved by more than one");
`endif

endmodule

`default_nettype wire

>>> test/sorted_set_insert_delete_tb.sv
// ---------------------------------------------------------------------------
// sorted_set_insert_delete_tb
// Self-checking bench for the sorted set. A scoreboard keeps its own ordered
// copy of the set and predicts every result of insert, delete, dump and the
// unused action. Stimulus starts with a directed pass over the extremes and
// the corner cases. A random pass follows that fills the store, hits full and
// duplicate-on-full, churns and drains it again. Both channels see random
// gaps and stalls.
// ---------------------------------------------------------------------------
`default_nettype none

module sorted_set_insert_delete_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sset_pkg::*;

  localparam int CAP        = CAPACITY_DEF;
  localparam int DIRECTED_N = 24;
  localparam int RANDOM_N   = 200;
  localparam int POOL_N     = 48;
  localparam int DRAIN_CYC  = 2 * CAP + 20;
  localparam int LIMIT      = 1_000_000;

  typedef struct packed {
    logic [STAT_W-1:0]       status;
    logic signed [VAL_W-1:0] entry;
    logic [SIZE_W-1:0]       size_now;
    logic                    final_res;
  } set_result_t;

  typedef bit bool_hit_t;

  class set_scoreboard;
    logic signed [VAL_W-1:0] members[$];
    set_result_t             awaited[$];
    int                      errors = 0;

    task report(string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      errors++;
    endtask

    function int lower_index(logic signed [VAL_W-1:0] v);
      int i;
      i = 0;
      while (i < members.size() && members[i] < v) i++;
      return i;
    endfunction

    function void push(logic [STAT_W-1:0] st, logic signed [VAL_W-1:0] e, logic last);
      set_result_t r;
      r.status    = st;
      r.entry     = e;
      r.size_now  = SIZE_W'(members.size());
      r.final_res = last;
      awaited.push_back(r);
    endfunction

    function void note_input(logic [ACT_W-1:0] act, logic signed [VAL_W-1:0] v);
      int  p;
      bool_hit_t hit;
      p   = lower_index(v);
      hit = (p < members.size()) && (members[p] == v);
      case (act)
        ACT_INSERT: begin
          if (hit) push(ST_DUP, '0, 1'b1);
          else if (members.size() >= CAP) push(ST_FULL, '0, 1'b1);
          else begin
            members.insert(p, v);
            push(ST_OK, '0, 1'b1);
          end
        end
        ACT_DELETE: begin
          if (hit) begin
            members.delete(p);
            push(ST_OK, '0, 1'b1);
          end else begin
            push(ST_NOTFOUND, '0, 1'b1);
          end
        end
        ACT_DUMP: begin
          if (members.size() == 0) push(ST_EMPTY, '0, 1'b1);
          else foreach (members[i]) push(ST_OK, members[i], i == members.size() - 1);
        end
        default: push(ST_OK, '0, 1'b1);
      endcase
    endfunction

    task check_result(logic [STAT_W-1:0] st, logic signed [VAL_W-1:0] e,
                      logic [SIZE_W-1:0] sz, logic last);
      set_result_t x;
      if (awaited.size() == 0) begin
        report($sformatf("unexpected transfer status=%0d entry=%0d", st, e));
        return;
      end
      x = awaited.pop_front();
      if (st !== x.status)
        report($sformatf("status got %0d exp %0d", st, x.status));
      if (e !== x.entry)
        report($sformatf("entry got %0d exp %0d", e, x.entry));
      if (sz !== x.size_now)
        report($sformatf("size_now got %0d exp %0d", sz, x.size_now));
      if (last !== x.final_res)
        report($sformatf("final_res got %0b exp %0b", last, x.final_res));
    endtask
  endclass

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic [ACT_W-1:0]        action = ACT_INSERT;
  logic signed [VAL_W-1:0] value = '0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic [STAT_W-1:0]       status;
  logic signed [VAL_W-1:0] entry;
  logic [SIZE_W-1:0]       size_now;
  logic                    final_res;

  set_scoreboard           sb = new();
  logic signed [VAL_W-1:0] pool[POOL_N];
  int                      items_sent = 0;
  bit                      send_quiet = 1'b0;
  int                      cycle_count = 0;
  int                      stall_left = 0;
  int                      mode_left = 0;
  bit                      recv_calm = 1'b0;

  sorted_set_insert_delete #(.CAPACITY(CAP)) dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .action    (action),
    .value     (value),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .entry     (entry),
    .size_now  (size_now),
    .final_res (final_res)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  function automatic logic signed [VAL_W-1:0] pick_value();
    if ($urandom_range(0, 99) < 70) return pool[$urandom_range(0, POOL_N - 1)];
    return $urandom;
  endfunction

  function automatic logic signed [VAL_W-1:0] held_value();
    if (sb.members.size() == 0) return pick_value();
    return sb.members[$urandom_range(0, sb.members.size() - 1)];
  endfunction

  // returns at the edge where the transfer happens
  task automatic send_item(logic [ACT_W-1:0] a, logic signed [VAL_W-1:0] v);
    int gap;
    if (items_sent % 30 == 0) send_quiet = ($urandom_range(0, 3) == 0);
    gap = send_quiet ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    action   <= a;
    value    <= v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_input(a, v);
    items_sent++;
  endtask

  // output side: stall stretches, calm periods with none
  always @(posedge clk) begin
    if (mode_left == 0) begin
      recv_calm = ($urandom_range(0, 3) == 0);
      mode_left = $urandom_range(50, 300);
    end else begin
      mode_left--;
    end
    if (stall_left > 0) stall_left--;
    else if (!recv_calm && $urandom_range(0, 99) < 30)
      stall_left = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 3) : $urandom_range(8, 40);
    out_stall <= (stall_left > 0);
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) sb.check_result(status, entry, size_now, final_res);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT) begin
      $display("sorted_set_insert_delete_tb: FAIL");
      $finish;
    end
  end

  initial begin
    int r;
    pool[0] = 32'sh8000_0000;
    pool[1] = 32'sh7FFF_FFFF;
    pool[2] = 32'sh0000_0000;
    pool[3] = 32'shFFFF_FFFF;
    for (int i = 4; i < POOL_N; i++) pool[i] = $urandom;

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // directed pass
    send_item(ACT_DUMP,   32'sh0);
    send_item(ACT_DELETE, 32'sh5);
    send_item(ACT_INSERT, 32'sh0);
    send_item(ACT_INSERT, 32'sh7FFF_FFFF);
    send_item(ACT_INSERT, 32'sh8000_0000);
    send_item(ACT_INSERT, 32'shFFFF_FFFF);
    send_item(ACT_INSERT, 32'sh1);
    send_item(ACT_INSERT, 32'sh0);
    send_item(ACT_INSERT, 32'sh8000_0000);
    send_item(ACT_DUMP,   32'shFFFF_FFFF);
    send_item(ACT_DELETE, 32'sh8000_0000);
    send_item(ACT_DELETE, 32'sh7FFF_FFFF);
    send_item(ACT_DELETE, 32'sh7);
    send_item(ACT_DELETE, 32'shFFFF_FFFF);
    send_item(ACT_NOP,    32'sh5A5A_A5A5);
    send_item(ACT_DUMP,   32'sh0);
    send_item(ACT_INSERT, 32'sh7FFF_FFFE);
    send_item(ACT_INSERT, 32'sh8000_0001);
    send_item(ACT_DUMP,   32'sh0);
    send_item(ACT_DELETE, 32'sh0);
    send_item(ACT_DELETE, 32'sh1);
    send_item(ACT_DELETE, 32'sh7FFF_FFFE);
    send_item(ACT_DELETE, 32'sh8000_0001);
    send_item(ACT_DUMP,   32'shA5A5_5A5A);

    // random pass: fill, full, churn, drain
    while (items_sent < DIRECTED_N + RANDOM_N) begin
      while (sb.members.size() < CAP) begin
        r = $urandom_range(0, 99);
        if (r < 88) send_item(ACT_INSERT, pick_value());
        else if (r < 94) send_item(ACT_DELETE, pick_value());
        else if (r < 98) send_item(ACT_DUMP, $urandom);
        else send_item(ACT_NOP, $urandom);
      end
      send_item(ACT_INSERT, held_value());
      send_item(ACT_INSERT, $urandom);
      send_item(ACT_DUMP, $urandom);
      repeat (20) begin
        r = $urandom_range(0, 99);
        if (r < 35) send_item(ACT_INSERT, pick_value());
        else if (r < 60) send_item(ACT_DELETE, held_value());
        else if (r < 80) send_item(ACT_DELETE, pick_value());
        else if (r < 95) send_item(ACT_DUMP, $urandom);
        else send_item(ACT_NOP, $urandom);
      end
      while (sb.members.size() > 0) begin
        r = $urandom_range(0, 99);
        if (r < 80) send_item(ACT_DELETE, held_value());
        else if (r < 90) send_item(ACT_DELETE, pick_value());
        else if (r < 95) send_item(ACT_INSERT, pick_value());
        else send_item(ACT_DUMP, $urandom);
      end
      send_item(ACT_DUMP, $urandom);
    end
    in_valid <= 1'b0;

    while (sb.awaited.size() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);

    if (sb.errors == 0) begin
      $display("sorted_set_insert_delete_tb: PASS");
    end else begin
      $display("sorted_set_insert_delete_tb: FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
